@@ design/lfcc_pkg.sv @@
`default_nettype none
package lfcc_pkg;

    localparam int SENSOR_BITS = 10;
    localparam int COUNT_BITS  = 13;

    localparam int THR_W  = 10;
    localparam int REG_W  = 12;
    localparam int CFG_AW = 3;
    localparam int DIR_W  = 2;
    localparam int CMD_W  = 3;

    // light_a, light_b, follow_enable, turn_cmd packed from bit 0
    localparam int IN_BITS  = 2 * SENSOR_BITS + 1 + CMD_W;
    localparam int IN_W     = ((IN_BITS + 7) / 8) * 8;
    localparam int OUT_BITS = 2 * DIR_W + 3;
    localparam int OUT_W    = ((OUT_BITS + 7) / 8) * 8;

    localparam int MARGIN    = 100;
    localparam int COUNT_MAX = (1 << COUNT_BITS) - 1;
    // wide enough for register plus margin and for any count
    localparam int LIM_W     = ((COUNT_BITS > REG_W + 1) ? COUNT_BITS : REG_W + 1) + 1;

    localparam logic [CFG_AW-1:0] CFG_THR_A    = 3'd0;
    localparam logic [CFG_AW-1:0] CFG_THR_B    = 3'd1;
    localparam logic [CFG_AW-1:0] CFG_HOLDOFF  = 3'd2;
    localparam logic [CFG_AW-1:0] CFG_TURN     = 3'd3;
    localparam logic [CFG_AW-1:0] CFG_STRAIGHT = 3'd4;

    localparam logic [REG_W-1:0] THR_RST      = 12'd736;
    localparam logic [REG_W-1:0] HOLDOFF_RST  = 12'd500;
    localparam logic [REG_W-1:0] TURN_RST     = 12'd800;
    localparam logic [REG_W-1:0] STRAIGHT_RST = 12'd200;

    localparam logic [COUNT_BITS-1:0] SLT_RST =
        COUNT_BITS'((500 > COUNT_MAX) ? COUNT_MAX : 500);
    localparam logic [COUNT_BITS-1:0] SC_RST =
        COUNT_BITS'((800 > COUNT_MAX) ? COUNT_MAX : 800);

    localparam logic [DIR_W-1:0] DIR_OFF = 2'd0;
    localparam logic [DIR_W-1:0] DIR_FWD = 2'd1;
    localparam logic [DIR_W-1:0] DIR_REV = 2'd2;

    localparam logic [CMD_W-1:0] CMD_LEFT     = 3'd1;
    localparam logic [CMD_W-1:0] CMD_STRAIGHT = 3'd2;
    localparam logic [CMD_W-1:0] CMD_RIGHT    = 3'd3;

endpackage
`default_nettype wire

@@ design/line_follower_crossing_control.sv @@
// Pipeline: two register stages; an accepted input beat is held in the input stage, and its
//   result moves to the output stage, which holds it until the receiver takes it.
// Throughput: one beat per cycle while the output is not stalled; the tick state updates as an item moves on.
// Reset (i_rst_n low, synchronous): both stages empty, registers to defaults,
//   counters to their preset values, crossing flag and wheel directions cleared.
`default_nettype none
module line_follower_crossing_control (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_cfg_we,
    input  wire logic [lfcc_pkg::CFG_AW-1:0]   i_cfg_addr,
    input  wire logic [lfcc_pkg::REG_W-1:0]    i_cfg_wdata,
    input  wire logic                          i_s_tvalid,
    output logic                               o_s_tready,
    // light_a, light_b, follow_enable, turn_cmd, zero fill
    input  wire logic [lfcc_pkg::IN_W-1:0]     i_s_tdata,
    output logic                               o_m_tvalid,
    input  wire logic                          i_m_tready,
    // left_dir, right_dir, in_crossing, crossing_found, turn_done, zero fill
    output logic [lfcc_pkg::OUT_W-1:0]         o_m_tdata
);
    import lfcc_pkg::*;

    logic [THR_W-1:0] r_thr_a, r_thr_b;
    logic [REG_W-1:0] r_holdoff, r_turn, r_straight;

    logic                  r_in_valid;
    logic [IN_BITS-1:0]    r_in;
    logic                  r_out_valid;
    logic [OUT_BITS-1:0]   r_out;

    logic [COUNT_BITS-1:0] r_slt, r_sc;
    logic                  r_cross;
    logic [DIR_W-1:0]      r_ldir, r_rdir;

    logic [COUNT_BITS-1:0] n_slt, n_sc;
    logic                  n_cross;
    logic [DIR_W-1:0]      n_ldir, n_rdir;
    logic                  found, done;

    logic                  advance;
    logic [SENSOR_BITS-1:0] la, lb;
    logic                  en;
    logic [CMD_W-1:0]      cmd;
    logic                  dark_a, dark_b;
    logic [COUNT_BITS-1:0] adv_slt, adv_sc;

    function automatic logic [COUNT_BITS-1:0] clamp_adv(
        input logic [COUNT_BITS-1:0] cnt,
        input logic [REG_W-1:0]      lim_reg
    );
        logic [LIM_W-1:0] lim;
        logic [LIM_W-1:0] c;
        lim = LIM_W'(lim_reg) + LIM_W'(MARGIN);
        if (lim > LIM_W'(COUNT_MAX - 1)) begin
            lim = LIM_W'(COUNT_MAX - 1);
        end
        c = LIM_W'(cnt);
        if (c > lim) begin
            c = lim;
        end
        c = c + LIM_W'(1);
        return c[COUNT_BITS-1:0];
    endfunction

    assign advance    = !r_out_valid || i_m_tready;
    assign o_s_tready = !r_in_valid || advance;
    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = OUT_W'(r_out);

    assign la  = r_in[SENSOR_BITS-1:0];
    assign lb  = r_in[2*SENSOR_BITS-1:SENSOR_BITS];
    assign en  = r_in[2*SENSOR_BITS];
    assign cmd = r_in[2*SENSOR_BITS+CMD_W:2*SENSOR_BITS+1];

    // sensors may be wider than the threshold registers
    localparam int CMP_W = (SENSOR_BITS > THR_W) ? SENSOR_BITS : THR_W;
    assign dark_a = CMP_W'(la) > CMP_W'(r_thr_a);
    assign dark_b = CMP_W'(lb) > CMP_W'(r_thr_b);

    assign adv_slt = clamp_adv(r_slt, r_holdoff);
    assign adv_sc  = clamp_adv(r_sc, r_turn);

    always_comb begin
        n_slt   = r_slt;
        n_sc    = r_sc;
        n_cross = r_cross;
        n_ldir  = r_ldir;
        n_rdir  = r_rdir;
        found   = 1'b0;
        done    = 1'b0;
        if (en) begin
            n_slt = adv_slt;
            n_sc  = adv_sc;
            if (dark_a && dark_b && !r_cross) begin
                if (LIM_W'(adv_slt) > LIM_W'(r_holdoff)) begin
                    n_cross = 1'b1;
                    n_sc    = '0;
                    found   = 1'b1;
                end
            end else if ((!dark_b && cmd == CMD_LEFT) || (!dark_a && cmd == CMD_RIGHT) ||
                         (cmd == CMD_STRAIGHT && (!dark_a || !dark_b))) begin
                if (r_cross &&
                    ((cmd == CMD_STRAIGHT && LIM_W'(adv_sc) > LIM_W'(r_straight)) ||
                     LIM_W'(adv_sc) > LIM_W'(r_turn))) begin
                    n_slt   = '0;
                    n_cross = 1'b0;
                    done    = 1'b1;
                end
            end

            if (n_cross) begin
                unique case (cmd)
                    CMD_LEFT: begin
                        n_ldir = dark_a ? DIR_REV : DIR_FWD;
                        n_rdir = DIR_FWD;
                    end
                    CMD_RIGHT: begin
                        n_rdir = dark_b ? DIR_REV : DIR_FWD;
                        n_ldir = DIR_FWD;
                    end
                    CMD_STRAIGHT: begin
                        n_ldir = DIR_FWD;
                        n_rdir = DIR_FWD;
                    end
                    default: begin
                        n_ldir = DIR_OFF;
                        n_rdir = DIR_OFF;
                    end
                endcase
            end else begin
                n_ldir = dark_a ? DIR_REV : DIR_FWD;
                n_rdir = dark_b ? DIR_REV : DIR_FWD;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr_a    <= THR_RST[THR_W-1:0];
            r_thr_b    <= THR_RST[THR_W-1:0];
            r_holdoff  <= HOLDOFF_RST;
            r_turn     <= TURN_RST;
            r_straight <= STRAIGHT_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                CFG_THR_A:    r_thr_a    <= i_cfg_wdata[THR_W-1:0];
                CFG_THR_B:    r_thr_b    <= i_cfg_wdata[THR_W-1:0];
                CFG_HOLDOFF:  r_holdoff  <= i_cfg_wdata;
                CFG_TURN:     r_turn     <= i_cfg_wdata;
                CFG_STRAIGHT: r_straight <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_slt       <= SLT_RST;
            r_sc        <= SC_RST;
            r_cross     <= 1'b0;
            r_ldir      <= DIR_OFF;
            r_rdir      <= DIR_OFF;
        end else begin
            if (o_s_tready) begin
                r_in_valid <= i_s_tvalid;
            end
            if (advance) begin
                r_out_valid <= r_in_valid;
                // tick state moves only with a real beat
                if (r_in_valid) begin
                    r_slt   <= n_slt;
                    r_sc    <= n_sc;
                    r_cross <= n_cross;
                    r_ldir  <= n_ldir;
                    r_rdir  <= n_rdir;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_tready && i_s_tvalid) begin
            r_in <= i_s_tdata[IN_BITS-1:0];
        end
        if (advance && r_in_valid) begin
            r_out <= {done, found, n_cross, n_rdir, n_ldir};
        end
    end

    a_found_sets_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out[2*DIR_W+1] |-> r_out[2*DIR_W])
        else $error("crossing_found without in_crossing");

    a_done_clears_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out[2*DIR_W+2] |-> !r_out[2*DIR_W])
        else $error("turn_done while still in crossing");

    a_pulses_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> !(r_out[2*DIR_W+1] && r_out[2*DIR_W+2]))
        else $error("found and done in the same beat");

    a_state_holds_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(advance && r_in_valid) |=> $stable(r_cross) && $stable(r_slt))
        else $error("tick state moved without a beat");

endmodule
`default_nettype wire

@@ sim/line_follower_crossing_control_tb.sv @@
`timescale 1ns / 1ps
`default_nettype none
module line_follower_crossing_control_tb;
    import lfcc_pkg::*;

    localparam logic [CMD_W-1:0] CMD_NONE = 3'd0;
    localparam logic [CMD_W-1:0] CMD_DEST = 3'd4;
    localparam logic [CMD_W-1:0] CMD_LAST = 3'd7;
    localparam int LIGHT_MAX   = (1 << SENSOR_BITS) - 1;
    localparam int CYCLE_LIMIT = 300000;
    localparam int HOLD_CYCLES = 80;

    typedef struct packed {
        logic [SENSOR_BITS-1:0] light_a;
        logic [SENSOR_BITS-1:0] light_b;
        logic                   enable;
        logic [CMD_W-1:0]       cmd;
    } t_reading;

    typedef struct packed {
        logic [DIR_W-1:0] motor_a;
        logic [DIR_W-1:0] motor_c;
        logic             in_x;
        logic             found;
        logic             done;
    } t_wheels;

    typedef struct packed {
        t_reading r;
        logic     typed;
        t_wheels  w;
    } t_tick_row;

    typedef struct packed {
        logic [REG_W-1:0] thr_a;
        logic [REG_W-1:0] thr_b;
        logic [REG_W-1:0] holdoff;
        logic [REG_W-1:0] turn;
        logic [REG_W-1:0] straight;
    } t_settings;

    logic              i_clk = 1'b0;
    logic              i_rst_n;
    logic              i_cfg_we;
    logic [CFG_AW-1:0] i_cfg_addr;
    logic [REG_W-1:0]  i_cfg_wdata;
    logic              i_s_tvalid;
    logic              o_s_tready;
    // light_a, light_b, follow_enable, turn_cmd, zero fill
    logic [IN_W-1:0]   i_s_tdata;
    logic              o_m_tvalid;
    logic              rx_ready = 1'b0;
    // left_dir, right_dir, in_crossing, crossing_found, turn_done, zero fill
    logic [OUT_W-1:0]  o_m_tdata;

    line_follower_crossing_control dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (rx_ready),
        .o_m_tdata   (o_m_tdata)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // follower state as the block should hold it
    t_settings        regs;
    logic [COUNT_BITS-1:0] since_turn_cnt;
    logic [COUNT_BITS-1:0] since_cross_cnt;
    logic             crossing_on;
    logic [DIR_W-1:0] left_wheel;
    logic [DIR_W-1:0] right_wheel;

    t_wheels pending_wheels[$];
    int      mismatches = 0;
    int      ticks_sent = 0;
    int      beats_seen = 0;
    int      crossings_seen = 0;
    int      turns_seen = 0;
    int      settings_used = 0;
    int      cycles = 0;

    function automatic logic [COUNT_BITS-1:0] clamp_step(input logic [COUNT_BITS-1:0] cnt,
                                                         input logic [REG_W-1:0] lim_reg);
        int lim;
        int c;
        lim = int'(lim_reg) + MARGIN;
        if (lim > COUNT_MAX - 1) lim = COUNT_MAX - 1;
        c = int'(cnt);
        if (c > lim) c = lim;
        return COUNT_BITS'(c + 1);
    endfunction

    function automatic void follow_tick(input t_reading r, output t_wheels w);
        logic dark_a;
        logic dark_b;
        logic turning;
        dark_a = r.light_a > regs.thr_a[THR_W-1:0];
        dark_b = r.light_b > regs.thr_b[THR_W-1:0];
        w = '0;
        if (r.enable) begin
            since_turn_cnt  = clamp_step(since_turn_cnt, regs.holdoff);
            since_cross_cnt = clamp_step(since_cross_cnt, regs.turn);
            turning = (!dark_b && r.cmd == CMD_LEFT) || (!dark_a && r.cmd == CMD_RIGHT) ||
                      (r.cmd == CMD_STRAIGHT && (!dark_a || !dark_b));
            if (dark_a && dark_b && !crossing_on) begin
                if (since_turn_cnt > regs.holdoff) begin
                    crossing_on     = 1'b1;
                    since_cross_cnt = '0;
                    w.found         = 1'b1;
                end
            end else if (turning) begin
                if (crossing_on &&
                    ((r.cmd == CMD_STRAIGHT && since_cross_cnt > regs.straight) ||
                     since_cross_cnt > regs.turn)) begin
                    since_turn_cnt = '0;
                    crossing_on    = 1'b0;
                    w.done         = 1'b1;
                end
            end
            if (crossing_on) begin
                case (r.cmd)
                    CMD_LEFT: begin
                        left_wheel  = dark_a ? DIR_REV : DIR_FWD;
                        right_wheel = DIR_FWD;
                    end
                    CMD_RIGHT: begin
                        right_wheel = dark_b ? DIR_REV : DIR_FWD;
                        left_wheel  = DIR_FWD;
                    end
                    CMD_STRAIGHT: begin
                        left_wheel  = DIR_FWD;
                        right_wheel = DIR_FWD;
                    end
                    default: begin
                        left_wheel  = DIR_OFF;
                        right_wheel = DIR_OFF;
                    end
                endcase
            end else begin
                left_wheel  = dark_a ? DIR_REV : DIR_FWD;
                right_wheel = dark_b ? DIR_REV : DIR_FWD;
            end
        end
        w.motor_a = left_wheel;
        w.motor_c = right_wheel;
        w.in_x    = crossing_on;
    endfunction

    function automatic t_tick_row row(input int la, input int lb, input logic en,
                                      input logic [CMD_W-1:0] cmd, input logic typed,
                                      input logic [DIR_W-1:0] a, input logic [DIR_W-1:0] c,
                                      input int x, input int f, input int d);
        t_tick_row t;
        t.r = '{SENSOR_BITS'(la), SENSOR_BITS'(lb), en, cmd};
        t.typed = typed;
        t.w = '{a, c, x[0], f[0], d[0]};
        return t;
    endfunction

    function automatic logic [SENSOR_BITS-1:0] dark_val(input logic [REG_W-1:0] thr);
        if (int'(thr) >= LIGHT_MAX) return SENSOR_BITS'(LIGHT_MAX);
        return SENSOR_BITS'($urandom_range(LIGHT_MAX, int'(thr) + 1));
    endfunction

    function automatic logic [SENSOR_BITS-1:0] light_val(input logic [REG_W-1:0] thr);
        return SENSOR_BITS'($urandom_range(int'(thr), 0));
    endfunction

    // offer one beat and hold it until taken
    task automatic offer_tick(input t_reading r, input logic typed, input t_wheels typed_w);
        t_wheels w;
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= IN_W'({r.cmd, r.enable, r.light_b, r.light_a});
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
        follow_tick(r, w);
        pending_wheels.push_back(typed ? typed_w : w);
        ticks_sent++;
    endtask

    task automatic drain;
        i_s_tvalid <= 1'b0;
        while (pending_wheels.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic apply_settings(input t_settings s);
        logic [CFG_AW-1:0] addr_list[5];
        logic [REG_W-1:0]  vals[5];
        addr_list = '{CFG_THR_A, CFG_THR_B, CFG_HOLDOFF, CFG_TURN, CFG_STRAIGHT};
        vals = '{s.thr_a, s.thr_b, s.holdoff, s.turn, s.straight};
        for (int k = 0; k < 5; k++) begin
            i_cfg_we    <= 1'b1;
            i_cfg_addr  <= addr_list[k];
            i_cfg_wdata <= vals[k];
            @(posedge i_clk);
        end
        i_cfg_we <= 1'b0;
        regs = s;
        settings_used++;
    endtask

    // runs of crossing approaches with a fixed command, plus plain noise
    task automatic run_drive(input int n_ticks, input logic gaps);
        t_reading         r;
        logic [CMD_W-1:0] cmd;
        logic             noise;
        int               scn_len;
        int               step;
        int               burst;
        int               gap;
        scn_len = 0;
        step    = 0;
        burst   = 0;
        noise   = 1'b0;
        cmd     = CMD_NONE;
        repeat (n_ticks) begin
            if (step >= scn_len) begin
                step    = 0;
                scn_len = $urandom_range(24, 4);
                noise   = ($urandom_range(4, 0) == 0);
                case ($urandom_range(9, 0))
                    0, 1, 2: cmd = CMD_LEFT;
                    3, 4:    cmd = CMD_STRAIGHT;
                    5, 6, 7: cmd = CMD_RIGHT;
                    8:       cmd = CMD_NONE;
                    default: cmd = CMD_W'($urandom_range(CMD_LAST, CMD_DEST));
                endcase
            end
            if (noise) begin
                r = t_reading'($urandom);
            end else begin
                r.enable = ($urandom_range(15, 0) != 0);
                r.cmd    = cmd;
                if (step < 2) begin
                    r.light_a = dark_val(regs.thr_a);
                    r.light_b = dark_val(regs.thr_b);
                end else begin
                    r.light_a = ($urandom_range(9, 0) < 3) ? dark_val(regs.thr_a)
                                                           : light_val(regs.thr_a);
                    r.light_b = ($urandom_range(9, 0) < 3) ? dark_val(regs.thr_b)
                                                           : light_val(regs.thr_b);
                end
            end
            step++;
            if (gaps) begin
                if (burst == 0) begin
                    burst = $urandom_range(16, 1);
                    gap   = $urandom_range(6, 1);
                    i_s_tvalid <= 1'b0;
                    repeat (gap) @(posedge i_clk);
                end
                burst--;
            end
            offer_tick(r, 1'b0, '0);
        end
    endtask

    // receiver: stall mode is redrawn each time the 6-bit stall phase wraps, one long hold-off early on
    int         hold_left = 0;
    logic       pressure_done = 1'b0;
    logic [5:0] stall_phase = '0;
    int         stall_mode = 0;

    always @(posedge i_clk) begin
        if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            rx_ready  <= 1'b0;
        end else if (!pressure_done && beats_seen >= 60) begin
            hold_left     <= HOLD_CYCLES;
            pressure_done <= 1'b1;
            rx_ready      <= 1'b0;
        end else begin
            stall_phase <= stall_phase + 1'b1;
            if (stall_phase == '0) stall_mode <= $urandom_range(2, 0);
            case (stall_mode)
                0:       rx_ready <= 1'b1;
                1:       rx_ready <= ($urandom_range(3, 0) != 0);
                default: rx_ready <= ($urandom_range(9, 0) < 3);
            endcase
        end
    end

    task automatic check_field(input string name, input int want, input int got);
        if (want != got) begin
            mismatches++;
            $display("%0t: beat %0d %s expected %0d got %0d", $time, beats_seen, name,
                     want, got);
        end
    endtask

    t_wheels seen_w;
    t_wheels want_w;

    always @(posedge i_clk) begin
        if (i_rst_n && o_m_tvalid && rx_ready) begin
            seen_w.motor_a = o_m_tdata[1:0];
            seen_w.motor_c = o_m_tdata[3:2];
            seen_w.in_x    = o_m_tdata[4];
            seen_w.found   = o_m_tdata[5];
            seen_w.done    = o_m_tdata[6];
            beats_seen++;
            if (seen_w.found) crossings_seen++;
            if (seen_w.done) turns_seen++;
            if (pending_wheels.size() == 0) begin
                mismatches++;
                $display("%0t: unexpected result beat, expected none got %h", $time,
                         o_m_tdata);
            end else begin
                want_w = pending_wheels.pop_front();
                check_field("left_dir", int'(want_w.motor_a), int'(seen_w.motor_a));
                check_field("right_dir", int'(want_w.motor_c), int'(seen_w.motor_c));
                check_field("in_crossing", int'(want_w.in_x), int'(seen_w.in_x));
                check_field("crossing_found", int'(want_w.found), int'(seen_w.found));
                check_field("turn_done", int'(want_w.done), int'(seen_w.done));
            end
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("line_follower_crossing_control: mismatch");
            $finish;
        end
    end

    t_tick_row opening[18];
    t_settings plan[5];
    int        plan_ticks[5];
    logic      plan_gaps[5];

    initial begin
        i_rst_n     = 1'b0;
        i_cfg_we    = 1'b0;
        i_cfg_addr  = '0;
        i_cfg_wdata = '0;
        i_s_tvalid  = 1'b0;
        i_s_tdata   = '0;

        regs            = '{THR_RST, THR_RST, HOLDOFF_RST, TURN_RST, STRAIGHT_RST};
        since_turn_cnt  = SLT_RST;
        since_cross_cnt = SC_RST;
        crossing_on     = 1'b0;
        left_wheel      = DIR_OFF;
        right_wheel     = DIR_OFF;

        // after reset: default thresholds and times
        opening[0]  = row(0, 0, 1'b0, CMD_NONE, 1'b1, DIR_OFF, DIR_OFF, 0, 0, 0);
        opening[1]  = row(0, 0, 1'b1, CMD_NONE, 1'b1, DIR_FWD, DIR_FWD, 0, 0, 0);
        opening[2]  = row(1023, 0, 1'b1, CMD_NONE, 1'b1, DIR_REV, DIR_FWD, 0, 0, 0);
        opening[3]  = row(0, 1023, 1'b1, CMD_NONE, 1'b1, DIR_FWD, DIR_REV, 0, 0, 0);
        // reading equal to the threshold is still light
        opening[4]  = row(736, 737, 1'b1, CMD_NONE, 1'b1, DIR_FWD, DIR_REV, 0, 0, 0);
        opening[5]  = row(1023, 1023, 1'b1, CMD_LEFT, 1'b1, DIR_REV, DIR_FWD, 1, 1, 0);
        opening[6]  = row(1023, 1023, 1'b0, CMD_LEFT, 1'b1, DIR_REV, DIR_FWD, 1, 0, 0);
        opening[7]  = row(0, 0, 1'b1, CMD_LEFT, 1'b1, DIR_FWD, DIR_FWD, 1, 0, 0);
        opening[8]  = row(1023, 1023, 1'b1, CMD_LEFT, 1'b1, DIR_REV, DIR_FWD, 1, 0, 0);
        // no usable turn while crossing: wheels stop
        opening[9]  = row(0, 0, 1'b1, CMD_NONE, 1'b1, DIR_OFF, DIR_OFF, 1, 0, 0);
        opening[10] = row(0, 0, 1'b1, CMD_DEST, 1'b1, DIR_OFF, DIR_OFF, 1, 0, 0);
        opening[11] = row(1023, 1023, 1'b1, CMD_LAST, 1'b1, DIR_OFF, DIR_OFF, 1, 0, 0);
        opening[12] = row(0, 1023, 1'b1, CMD_RIGHT, 1'b1, DIR_FWD, DIR_REV, 1, 0, 0);
        opening[13] = row(1023, 0, 1'b1, CMD_RIGHT, 1'b1, DIR_FWD, DIR_FWD, 1, 0, 0);
        opening[14] = row(0, 0, 1'b1, CMD_STRAIGHT, 1'b1, DIR_FWD, DIR_FWD, 1, 0, 0);
        opening[15] = row(512, 900, 1'b1, CMD_STRAIGHT, 1'b0, '0, '0, 0, 0, 0);
        opening[16] = row(5, 1000, 1'b0, CMD_RIGHT, 1'b0, '0, '0, 0, 0, 0);
        opening[17] = row(737, 736, 1'b1, CMD_NONE, 1'b0, '0, '0, 0, 0, 0);

        plan[0] = '{12'd512, 12'd512, 12'd3, 12'd6, 12'd2};
        plan[1] = '{12'd0, 12'd1023, 12'd0, 12'd0, 12'd0};
        plan[2] = '{12'd1023, 12'd0, 12'd4000, 12'd4000, 12'd4000};
        plan[3] = '{12'd300, 12'd700, 12'd10, 12'd20, 12'd5};
        plan[4] = '{REG_W'($urandom_range(900, 100)), REG_W'($urandom_range(900, 100)),
                    REG_W'($urandom_range(30, 0)), REG_W'($urandom_range(30, 0)),
                    REG_W'($urandom_range(30, 0))};
        plan_ticks = '{140, 60, 60, 140, 150};
        plan_gaps  = '{1'b1, 1'b0, 1'b1, 1'b0, 1'b1};

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (opening[i]) offer_tick(opening[i].r, opening[i].typed, opening[i].w);
        drain();

        for (int p = 0; p < 5; p++) begin
            apply_settings(plan[p]);
            run_drive(plan_ticks[p], plan_gaps[p]);
            drain();
        end

        $display("%0d ticks over %0d register settings after reset defaults",
                 ticks_sent, settings_used);
        $display("%0d crossings entered, %0d turns completed, one long output stall",
                 crossings_seen, turns_seen);
        if (mismatches == 0) begin
            $display("line_follower_crossing_control: match");
        end else begin
            $display("line_follower_crossing_control: mismatch");
        end
        $finish;
    end

endmodule
`default_nettype wire
